>>> hdl/lcdseq_pkg.sv
// Shared types, codes and constants for the character LCD bus sequencer.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package lcdseq_pkg;

    // Widths fixed by the item and register formats
    localparam int FUNC_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int COLUMN_W   = 6;
    localparam int STEP_W     = 4;
    localparam int WAIT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int COUNTER_BITS_DEFAULT = 16;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INIT    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMMAND = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DATA    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CURSOR  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_EXTRA  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_UP     = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  ENABLE_PULSE_RST = 8'd2;
    localparam logic [9:0]  SETTLE_RST       = 10'd50;
    localparam logic [15:0] CLEAR_EXTRA_RST  = 16'd2000;
    localparam logic [15:0] POWER_UP_RST     = 16'd50000;

    // LCD command bytes
    localparam logic [BYTE_W-1:0] LCD_WAKE       = 8'h30;
    localparam logic [BYTE_W-1:0] LCD_FUNC_SET   = 8'h38;
    localparam logic [BYTE_W-1:0] LCD_DISP_OFF   = 8'h08;
    localparam logic [BYTE_W-1:0] LCD_CLEAR      = 8'h01;
    localparam logic [BYTE_W-1:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [BYTE_W-1:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [BYTE_W-1:0] LCD_ROW1_BASE  = 8'h40;
    localparam logic [BYTE_W-1:0] LCD_SET_DDRAM  = 8'h80;

    // Init sequence steps
    localparam logic [STEP_W-1:0] STEP_NONE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_POWERUP   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WAKE_FIRST = 4'd2;
    localparam logic [STEP_W-1:0] STEP_WAKE_LAST = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CLEAR     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LAST      = 4'd9;

    // Item kinds after classification
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;
    localparam logic [1:0] KIND_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic              rs;
        logic [BYTE_W-1:0] data;
    } item_t;

    // Byte sent at a given init step
    function automatic logic [BYTE_W-1:0] init_byte(input logic [STEP_W-1:0] step);
        logic [BYTE_W-1:0] b;
        case (step)
            4'd2, 4'd3, 4'd4: b = LCD_WAKE;
            4'd5:             b = LCD_FUNC_SET;
            4'd6:             b = LCD_DISP_OFF;
            4'd7:             b = LCD_CLEAR;
            4'd8:             b = LCD_ENTRY_MODE;
            4'd9:             b = LCD_DISP_ON;
            default:          b = '0;
        endcase
        return b;
    endfunction

    // Wait after each wake-up pulse
    function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] step);
        logic [WAIT_W-1:0] w;
        case (step)
            4'd2:    w = 16'd5000;
            4'd3:    w = 16'd150;
            4'd4:    w = 16'd50;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lcdseq_if.sv
// Channel interfaces: request input, result output and configuration write.
// Depends on lcdseq_pkg for field widths.
`default_nettype none

interface lcdseq_req_if;
    logic                              valid;
    logic                              ready;
    logic [lcdseq_pkg::FUNC_W-1:0]     func;
    logic [lcdseq_pkg::BYTE_W-1:0]     byte_value;
    logic                              row;
    logic [lcdseq_pkg::COLUMN_W-1:0]   column;

    modport source (output valid, func, byte_value, row, column, input ready);
    modport sink   (input valid, func, byte_value, row, column, output ready);
endinterface

interface lcdseq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          rs_pin;
    logic                          rw_pin;
    logic                          enable_pin;
    logic [lcdseq_pkg::BYTE_W-1:0] data_bus;
    logic                          busy_res;
    logic                          accepted;

    modport source (output valid, rs_pin, rw_pin, enable_pin, data_bus, busy_res, accepted,
                    input ready);
    modport sink   (input valid, rs_pin, rw_pin, enable_pin, data_bus, busy_res, accepted,
                    output ready);
endinterface

interface lcdseq_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lcdseq_pkg::CFG_IDX_W-1:0]  index;
    logic [lcdseq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/lcdseq_front.sv
// Front end: takes request transfers and classifies them into queue entries.
// Depends on lcdseq_pkg and lcdseq_if.
`default_nettype none

module lcdseq_front (
    lcdseq_req_if.sink          req,
    input  wire logic           q_full,
    output logic                push,
    output lcdseq_pkg::item_t   push_item
);

    logic [lcdseq_pkg::BYTE_W-1:0] cursor_addr;

    // Take a transfer whenever the queue has room
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    // Cursor address: row base plus column; the set-address bit is added when classifying
    assign cursor_addr = (req.row ? lcdseq_pkg::LCD_ROW1_BASE : '0)
                       + lcdseq_pkg::BYTE_W'(req.column);

    // Classify the function code
    always_comb
    begin
        push_item.kind = lcdseq_pkg::KIND_NONE;
        push_item.rs   = 1'b0;
        push_item.data = req.byte_value;
        case (req.func)
            lcdseq_pkg::FUNC_TICK:
            begin
                push_item.kind = lcdseq_pkg::KIND_TICK;
            end
            lcdseq_pkg::FUNC_INIT:
            begin
                push_item.kind = lcdseq_pkg::KIND_INIT;
            end
            lcdseq_pkg::FUNC_COMMAND:
            begin
                push_item.kind = lcdseq_pkg::KIND_WRITE;
            end
            lcdseq_pkg::FUNC_DATA:
            begin
                push_item.kind = lcdseq_pkg::KIND_WRITE;
                push_item.rs   = 1'b1;
            end
            lcdseq_pkg::FUNC_CURSOR:
            begin
                push_item.kind = lcdseq_pkg::KIND_WRITE;
                push_item.data = lcdseq_pkg::LCD_SET_DDRAM | cursor_addr;
            end
            default:
            begin
                push_item.kind = lcdseq_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/lcdseq_queue.sv
// Short FIFO between the front end and the bus sequencer.
// Depends on lcdseq_pkg for the entry type and depth.
`default_nettype none

module lcdseq_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  lcdseq_pkg::item_t       push_item,
    input  wire logic               pop,
    output logic                    full,
    output logic                    q_valid,
    output lcdseq_pkg::item_t       q_item
);

    localparam int DEPTH  = lcdseq_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = lcdseq_pkg::QPTR_W;
    localparam int CNT_W  = lcdseq_pkg::QCNT_W;

    lcdseq_pkg::item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lcdseq_back.sv
// Back end: configuration registers, the bus phase sequencer and the result register.
// Depends on lcdseq_pkg and lcdseq_if.
`default_nettype none

module lcdseq_back #(
    parameter int COUNTER_BITS = lcdseq_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  lcdseq_pkg::item_t   q_item,
    output logic                pop,
    lcdseq_cfg_if.sink          cfg,
    lcdseq_rsp_if.source        rsp
);

    localparam int CB = COUNTER_BITS;
    localparam logic [31:0] CNT_MAX = (32'd1 << CB) - 32'd1;
    // Longest chain of zero-length waits one item can run through
    localparam int CHAIN = 4;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_POWERUP = 3'd1;
    localparam logic [2:0] PH_EHIGH   = 3'd2;
    localparam logic [2:0] PH_ELOW    = 3'd3;
    localparam logic [2:0] PH_SETTLE  = 3'd4;
    localparam logic [2:0] PH_EXTRA   = 3'd5;

    typedef struct packed {
        logic [2:0]                        phase;
        logic [CB-1:0]                     cnt;
        logic [lcdseq_pkg::STEP_W-1:0]     step;
        logic                              rs;
        logic [lcdseq_pkg::BYTE_W-1:0]     data;
        logic                              en;
    } seq_t;

    // Clamp a loaded wait to the counter range
    function automatic logic [CB-1:0] sat_cnt(input logic [lcdseq_pkg::WAIT_W-1:0] n);
        logic [31:0] w;
        w = 32'(n);
        return (w > CNT_MAX) ? CB'(CNT_MAX) : CB'(w);
    endfunction

    function automatic seq_t start_write(input seq_t s, input logic rs,
                                         input logic [lcdseq_pkg::BYTE_W-1:0] b,
                                         input logic [CB-1:0] pulse);
        seq_t r;
        r       = s;
        r.rs    = rs;
        r.data  = b;
        r.en    = 1'b1;
        r.phase = PH_EHIGH;
        r.cnt   = pulse;
        return r;
    endfunction

    function automatic seq_t finish_segment(input seq_t s, input logic [CB-1:0] pulse);
        seq_t r;
        logic [lcdseq_pkg::STEP_W-1:0] nstep;
        r     = s;
        nstep = s.step + 1'b1;
        if (s.step == lcdseq_pkg::STEP_NONE || s.step >= lcdseq_pkg::STEP_LAST)
        begin
            r.step  = lcdseq_pkg::STEP_NONE;
            r.phase = PH_IDLE;
            r.cnt   = '0;
        end
        else
        begin
            r.step = nstep;
            r      = start_write(r, 1'b0, lcdseq_pkg::init_byte(nstep), pulse);
        end
        return r;
    endfunction

    function automatic seq_t advance(input seq_t s, input logic [CB-1:0] pulse,
                                     input logic [CB-1:0] settle, input logic [CB-1:0] extra);
        seq_t r;
        r = s;
        case (s.phase)
            PH_POWERUP:
            begin
                r = finish_segment(s, pulse);
            end
            PH_EHIGH:
            begin
                r.en    = 1'b0;
                r.phase = PH_ELOW;
                r.cnt   = pulse;
            end
            PH_ELOW:
            begin
                r.phase = PH_SETTLE;
                if (s.step >= lcdseq_pkg::STEP_WAKE_FIRST && s.step <= lcdseq_pkg::STEP_WAKE_LAST)
                begin
                    r.cnt = sat_cnt(lcdseq_pkg::init_wait(s.step));
                end
                else
                begin
                    r.cnt = settle;
                end
            end
            PH_SETTLE:
            begin
                if (s.step == lcdseq_pkg::STEP_CLEAR)
                begin
                    r.phase = PH_EXTRA;
                    r.cnt   = extra;
                end
                else
                begin
                    r = finish_segment(s, pulse);
                end
            end
            PH_EXTRA:
            begin
                r = finish_segment(s, pulse);
            end
            default:
            begin
                r.step  = lcdseq_pkg::STEP_NONE;
                r.phase = PH_IDLE;
                r.cnt   = '0;
            end
        endcase
        return r;
    endfunction

    // Configuration registers
    logic [7:0]  pulse_cfg_reg;
    logic [9:0]  settle_cfg_reg;
    logic [15:0] extra_cfg_reg;
    logic [15:0] powerup_cfg_reg;

    // Sequencer state and result register
    seq_t        seq_reg, seq_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_rs_reg, out_en_reg, out_busy_reg, out_acc_reg;
    logic [lcdseq_pkg::BYTE_W-1:0] out_data_reg;
    logic        acc_next;

    logic [CB-1:0] pulse_load, settle_load, extra_load, powerup_load;
    seq_t          chain [CHAIN + 1];
    logic          idle;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_cfg_reg   <= lcdseq_pkg::ENABLE_PULSE_RST;
            settle_cfg_reg  <= lcdseq_pkg::SETTLE_RST;
            extra_cfg_reg   <= lcdseq_pkg::CLEAR_EXTRA_RST;
            powerup_cfg_reg <= lcdseq_pkg::POWER_UP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lcdseq_pkg::REG_ENABLE_PULSE: pulse_cfg_reg   <= cfg.data[7:0];
                lcdseq_pkg::REG_SETTLE:       settle_cfg_reg  <= cfg.data[9:0];
                lcdseq_pkg::REG_CLEAR_EXTRA:  extra_cfg_reg   <= cfg.data;
                lcdseq_pkg::REG_POWER_UP:     powerup_cfg_reg <= cfg.data;
                default:                      pulse_cfg_reg   <= pulse_cfg_reg;
            endcase
        end
    end

    // Loaded wait lengths; a zero pulse length acts as one
    assign pulse_load   = sat_cnt((pulse_cfg_reg == '0) ? 16'd1 : 16'(pulse_cfg_reg));
    assign settle_load  = sat_cnt(16'(settle_cfg_reg));
    assign extra_load   = sat_cnt(extra_cfg_reg);
    assign powerup_load = sat_cnt(powerup_cfg_reg);

    // Pop when the result register is free or being drained
    assign pop  = q_valid && (!out_valid_reg || rsp.ready);
    assign idle = (seq_reg.phase == PH_IDLE);

    // Apply the item, then run through any waits that end at once
    always_comb
    begin
        chain[0] = seq_reg;
        acc_next = 1'b0;
        case (q_item.kind)
            lcdseq_pkg::KIND_TICK:
            begin
                if (!idle)
                begin
                    chain[0].cnt = seq_reg.cnt - 1'b1;
                end
            end
            lcdseq_pkg::KIND_INIT:
            begin
                if (idle)
                begin
                    acc_next       = 1'b1;
                    chain[0].step  = lcdseq_pkg::STEP_POWERUP;
                    chain[0].phase = PH_POWERUP;
                    chain[0].cnt   = powerup_load;
                end
            end
            lcdseq_pkg::KIND_WRITE:
            begin
                if (idle)
                begin
                    acc_next = 1'b1;
                    chain[0] = start_write(seq_reg, q_item.rs, q_item.data, pulse_load);
                end
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
        for (int i = 0; i < CHAIN; i++)
        begin
            if (chain[i].phase != PH_IDLE && chain[i].cnt == '0)
            begin
                chain[i + 1] = advance(chain[i], pulse_load, settle_load, extra_load);
            end
            else
            begin
                chain[i + 1] = chain[i];
            end
        end
        seq_next = pop ? chain[CHAIN] : seq_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the next pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_rs_reg   <= seq_next.rs;
            out_en_reg   <= seq_next.en;
            out_data_reg <= seq_next.data;
            out_busy_reg <= (seq_next.phase != PH_IDLE);
            out_acc_reg  <= acc_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.rs_pin     = out_rs_reg;
    assign rsp.rw_pin     = 1'b0;
    assign rsp.enable_pin = out_en_reg;
    assign rsp.data_bus   = out_data_reg;
    assign rsp.busy_res   = out_busy_reg;
    assign rsp.accepted   = out_acc_reg;

`ifndef SYNTHESIS
    a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg.phase != PH_IDLE) |-> (seq_reg.cnt != '0))
        else $error("sequencer busy with an expired countdown");

    a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg.phase == PH_IDLE) |-> (seq_reg.step == lcdseq_pkg::STEP_NONE))
        else $error("init step left over in idle");

    a_enable_in_high: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg.en |-> (seq_reg.phase == PH_EHIGH))
        else $error("enable high outside the high phase");

    a_taken_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && acc_next) |=> (out_busy_reg && out_valid_reg))
        else $error("accepted request left the sequencer idle");
`endif

endmodule

`default_nettype wire

>>> hdl/char_lcd_bus_sequencer.sv
// Top level of the character LCD bus sequencer: front end, queue and bus sequencer.
// Depends on lcdseq_pkg, lcdseq_if, lcdseq_front, lcdseq_queue and lcdseq_back.
//
// Each item on req is a one-microsecond tick or a request (init, command byte, data byte,
// cursor move) and yields exactly one result on rsp with the bus levels after that item.
// One item is taken per clock when rsp keeps up; its result is registered after the queue.
// The front end classifies items into a two-entry queue; the sequencer applies one item per
// cycle when rsp keeps up, its phase countdown resolving any chain of zero-length waits (at
// most four phase steps) within that cycle. Configuration writes on cfg are always taken;
// the user must hold them to idle periods (not enforced). No clearing pass follows reset.
`default_nettype none

module char_lcd_bus_sequencer #(
    parameter int COUNTER_BITS = lcdseq_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    lcdseq_req_if.sink      req,
    lcdseq_rsp_if.source    rsp,
    lcdseq_cfg_if.sink      cfg
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;
    lcdseq_pkg::item_t push_item;
    lcdseq_pkg::item_t q_item;

    lcdseq_front u_front (
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    lcdseq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    lcdseq_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire
